FILE: hdl/wbss_pkg.sv
// ----------------------------------------------------------------------------
// wbss_pkg
// Shared types and constants for the wildcard byte signature search.
// ----------------------------------------------------------------------------
package wbss_pkg;

    // Longest pattern, in bytes, and the widths that follow from it.
    localparam int PAT_MAX   = 16;
    localparam int PAT_IDX_W = 4;   // indexes pattern bytes 0..PAT_MAX-1
    localparam int LEN_W     = 5;   // holds 0..PAT_MAX

    localparam int WR_DATA_W  = 64;
    localparam int WR_INDEX_W = 3;

    // Configuration register indexes.
    typedef enum logic [WR_INDEX_W-1:0] {
        REG_PAT_LOW   = 3'd0,
        REG_PAT_HIGH  = 3'd1,
        REG_CARE_MASK = 3'd2,
        REG_PAT_LEN   = 3'd3,
        REG_BASE_ADDR = 3'd4,
        REG_START_OFF = 3'd5
    } reg_index_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_NONE       = 2'd0,
        STATUS_UNIQUE     = 2'd1,
        STATUS_SEVERAL    = 2'd2,
        STATUS_NO_LITERAL = 2'd3
    } status_t;

endpackage

FILE: hdl/wbss_in_if.sv
// ----------------------------------------------------------------------------
// wbss_in_if
// Byte stream channel: one memory byte per beat, with an end-of-region flag.
// ----------------------------------------------------------------------------
interface wbss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: hdl/wbss_out_if.sv
// ----------------------------------------------------------------------------
// wbss_out_if
// Result channel: one search result per beat.
// ----------------------------------------------------------------------------
interface wbss_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] match_address;

    modport source (output valid, output status, output match_address, input ready);
    modport sink   (input valid, input status, input match_address, output ready);
endinterface

FILE: hdl/wildcard_byte_signature_search.sv
// ----------------------------------------------------------------------------
// wildcard_byte_signature_search
// Streams memory bytes through a sliding window and searches for a masked
// byte pattern; reports one result per region.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle, with no gaps of its own: each byte beat
// shifts the 16-byte window and compares the newest window against the
// pattern in the same cycle, so throughput is one byte per clock. Windows
// that overlap an earlier match are skipped, so matches never overlap. When
// the beat flagged last_byte is taken, the result (status and address) is
// loaded into the output register on that same edge, is offered from the next
// cycle on, and stays there until taken; the byte input stalls only while
// that register is full and not being drained.
// Status: 0 no match, 1 unique match, 2 several matches, 3 no literal
// (care) bytes within the pattern length. match_address is base_address plus
// the offset of the last match minus the start distance register, modulo
// 2^32, and is zero for status 0 and 3. After the last byte all stream state
// is cleared; the configuration registers are kept. pattern_length 0 acts as
// 1 and values above 16 act as 16. Write configuration only while the block
// is idle.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_search
    import wbss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration write port
    input  logic                  wr_en,
    input  logic [WR_INDEX_W-1:0] wr_index,
    input  logic [WR_DATA_W-1:0]  wr_data,

    wbss_in_if.sink               bytes,
    wbss_out_if.source            results
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [8*PAT_MAX-1:0] pattern_reg;      // byte i at bits 8i+7:8i
    logic [PAT_MAX-1:0]   care_mask_reg;
    logic [LEN_W-1:0]     pattern_length_reg;
    logic [31:0]          base_address_reg;
    logic [15:0]          start_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg        <= '0;
            care_mask_reg      <= '0;
            pattern_length_reg <= LEN_W'(1);
            base_address_reg   <= '0;
            start_dist_reg     <= '0;
        end
        else if (wr_en)
        begin
            case (reg_index_t'(wr_index))
                REG_PAT_LOW:   pattern_reg[63:0]   <= wr_data;
                REG_PAT_HIGH:  pattern_reg[127:64] <= wr_data;
                REG_CARE_MASK: care_mask_reg       <= wr_data[PAT_MAX-1:0];
                REG_PAT_LEN:   pattern_length_reg  <= wr_data[LEN_W-1:0];
                REG_BASE_ADDR: base_address_reg    <= wr_data[31:0];
                REG_START_OFF: start_dist_reg      <= wr_data[15:0];
                default:       ;
            endcase
        end
    end

    // Effective length: clamp to 1..PAT_MAX.
    logic [LEN_W-1:0] eff_len;
    always_comb
    begin
        if (pattern_length_reg == '0)
            eff_len = LEN_W'(1);
        else if (pattern_length_reg > LEN_W'(PAT_MAX))
            eff_len = LEN_W'(PAT_MAX);
        else
            eff_len = pattern_length_reg;
    end

    // ------------------------------------------------------------------
    // Stream state
    // ------------------------------------------------------------------
    logic [7:0]       window_reg  [PAT_MAX];  // [k]: byte k beats before newest
    logic [7:0]       window_next [PAT_MAX];
    logic [LEN_W-1:0] fill_reg, fill_next;
    logic [31:0]      seen_reg, seen_next;
    logic [1:0]       matches_reg, matches_next;
    logic [31:0]      last_off_reg, last_off_next;
    logic [LEN_W-1:0] skip_reg, skip_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    status_t          status_reg, status_next;
    logic [31:0]      addr_reg, addr_next;

    logic accept;
    assign bytes.ready = !out_valid_reg || results.ready;
    assign accept      = bytes.valid && bytes.ready;

    // Shifted window with the incoming byte at slot 0.
    logic [7:0] win_shift [PAT_MAX];
    always_comb
    begin
        win_shift[0] = bytes.data_byte;
        for (int k = 1; k < PAT_MAX; k++)
            win_shift[k] = window_reg[k-1];
    end

    // Masked compare. Window slot j lines up with pattern byte len-1-j;
    // slots at or beyond the length take no part.
    logic [PAT_MAX-1:0] mismatch;
    logic [PAT_MAX-1:0] len_mask;
    logic               window_hit;
    logic               has_literal;
    always_comb
    begin
        logic [LEN_W-1:0]     pidx;
        logic [PAT_IDX_W-1:0] p;
        pidx = '0;
        p    = '0;
        for (int j = 0; j < PAT_MAX; j++)
        begin
            pidx        = eff_len - LEN_W'(j) - LEN_W'(1);
            p           = pidx[PAT_IDX_W-1:0];
            len_mask[j] = LEN_W'(j) < eff_len;
            mismatch[j] = len_mask[j] && care_mask_reg[p]
                          && (win_shift[j] != pattern_reg[8*p +: 8]);
        end
        window_hit  = (mismatch == '0);
        has_literal = |(care_mask_reg & len_mask);
    end

    // Next state
    always_comb
    begin
        logic [LEN_W-1:0] fill_inc;
        logic [31:0]      seen_inc;

        fill_inc = (fill_reg == LEN_W'(PAT_MAX)) ? fill_reg : fill_reg + LEN_W'(1);
        seen_inc = seen_reg + 32'd1;

        window_next   = window_reg;
        fill_next     = fill_reg;
        seen_next     = seen_reg;
        matches_next  = matches_reg;
        last_off_next = last_off_reg;
        skip_next     = skip_reg;
        status_next   = status_reg;
        addr_next     = addr_reg;

        // result register drains on its own beat
        out_valid_next = out_valid_reg && !results.ready;

        if (accept)
        begin
            window_next = win_shift;
            fill_next   = fill_inc;
            seen_next   = seen_inc;

            // only windows fully inside the stream are compared
            if (fill_inc >= eff_len)
            begin
                if (skip_reg != '0)
                    skip_next = skip_reg - LEN_W'(1);
                else if (window_hit)
                begin
                    if (matches_reg != 2'd2)
                        matches_next = matches_reg + 2'd1;
                    last_off_next = seen_inc - 32'(eff_len);
                    skip_next     = eff_len - LEN_W'(1);
                end
            end

            if (bytes.last_byte)
            begin
                out_valid_next = 1'b1;
                if (!has_literal)
                begin
                    status_next = STATUS_NO_LITERAL;
                    addr_next   = '0;
                end
                else if (matches_next == 2'd0)
                begin
                    status_next = STATUS_NONE;
                    addr_next   = '0;
                end
                else
                begin
                    status_next = (matches_next == 2'd2) ? STATUS_SEVERAL : STATUS_UNIQUE;
                    addr_next   = base_address_reg + last_off_next
                                  - {16'd0, start_dist_reg};
                end

                // region done: back to a clean stream
                for (int k = 0; k < PAT_MAX; k++)
                    window_next[k] = '0;
                fill_next     = '0;
                seen_next     = '0;
                matches_next  = '0;
                last_off_next = '0;
                skip_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PAT_MAX; k++)
                window_reg[k] <= '0;
            fill_reg      <= '0;
            seen_reg      <= '0;
            matches_reg   <= '0;
            last_off_reg  <= '0;
            skip_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            window_reg    <= window_next;
            fill_reg      <= fill_next;
            seen_reg      <= seen_next;
            matches_reg   <= matches_next;
            last_off_reg  <= last_off_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        addr_reg   <= addr_next;
    end

    assign results.valid         = out_valid_reg;
    assign results.status        = status_reg;
    assign results.match_address = addr_reg;

endmodule
